// ----- sv/b64sc_pkg.sv -----
// Shared types, character codes and alphabet functions for the Base64 codec.
// No dependencies; imported by every module of the codec.
package b64sc_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;
	localparam logic [7:0] CHAR_PAD     = 8'h3D;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// One finished group: up to four result items and how to tag them.
	typedef struct packed {
		logic [3:0][7:0] data;       // data[0] goes out first
		logic [1:0]      final_idx;  // index of the last item of the group
		logic            last;
		logic            err;
	} job_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sextet_t;

	function automatic logic [7:0] b64_char(input logic [5:0] s);
		logic [7:0] c;
		c = 8'(s);
		if (s < 6'd26)      return CHAR_UPPER_A + c;
		else if (s < 6'd52) return CHAR_LOWER_A + c - 8'd26;
		else if (s < 6'd62) return CHAR_DIGIT_0 + c - 8'd52;
		else if (s == 6'd62) return CHAR_PLUS;
		else                return CHAR_SLASH;
	endfunction

	function automatic sextet_t b64_sextet(input logic [7:0] c);
		sextet_t r;
		r.ok = 1'b1;
		if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})      r.val = 6'(c - CHAR_UPPER_A);
		else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) r.val = 6'(c - CHAR_LOWER_A + 8'd26);
		else if (c inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) r.val = 6'(c - CHAR_DIGIT_0 + 8'd52);
		else if (c == CHAR_PLUS)  r.val = 6'd62;
		else if (c == CHAR_SLASH) r.val = 6'd63;
		else if (c == CHAR_PAD)   r.val = 6'd0;
		else begin
			r.ok  = 1'b0;
			r.val = 6'd0;
		end
		return r;
	endfunction

endpackage

// ----- sv/b64sc_front.sv -----
// Front end of the Base64 codec: holds the mode, collects a group and
// builds a job when the group closes. Depends on b64sc_pkg.
module b64sc_front import b64sc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       mode_we,
	input  logic       mode_wdata,
	input  logic       accept,
	input  logic [7:0] in_data,
	input  logic       in_last,
	output logic       job_push,
	output job_t       job
);

	logic        mode_q;
	logic [23:0] bits_q;
	logic [1:0]  count_q;
	logic [1:0]  pads_q;
	logic        bad_q;

	logic [23:0] bits_d;
	logic [1:0]  count_d;
	logic [1:0]  pads_d;
	logic        bad_d;
	logic        close;

	logic [23:0] enc_bits, enc_shift;
	logic [1:0]  enc_cnt;
	sextet_t     sx;
	logic        is_pad;
	logic [23:0] dec_bits;
	logic [1:0]  dec_pads;
	logic        dec_bad;

	always_comb begin
		enc_cnt  = count_q + 2'd1;
		enc_bits = {bits_q[15:0], in_data};
		case (enc_cnt)
			2'd1:    enc_shift = {enc_bits[7:0], 16'd0};
			2'd2:    enc_shift = {enc_bits[15:0], 8'd0};
			default: enc_shift = enc_bits;
		endcase

		sx       = b64_sextet(in_data);
		is_pad   = (in_data == CHAR_PAD);
		dec_bits = {bits_q[17:0], sx.val};
		dec_pads = pads_q | {is_pad && count_q == 2'd2, is_pad && count_q == 2'd3};
		dec_bad  = bad_q | ~sx.ok;

		close   = 1'b0;
		bits_d  = bits_q;
		count_d = count_q;
		pads_d  = pads_q;
		bad_d   = bad_q;
		job     = '0;

		if (mode_q == MODE_ENCODE) begin
			for (int k = 0; k < 4; k++) begin
				if (2'(k) <= enc_cnt || k == 0)
					job.data[k] = b64_char(enc_shift[18 - 6 * k +: 6]);
				else
					job.data[k] = CHAR_PAD;
			end
			job.final_idx = 2'd3;
			job.last      = in_last;
			job.err       = 1'b0;
			if (enc_cnt == 2'd3 || in_last) begin
				close = 1'b1;
			end else begin
				bits_d  = enc_bits;
				count_d = enc_cnt;
			end
		end else begin
			if (count_q == 2'd3) begin
				close         = 1'b1;
				job.data[0]   = dec_bits[23:16];
				job.data[1]   = dec_bits[15:8];
				job.data[2]   = dec_bits[7:0];
				job.final_idx = in_last ? 2'd2 - 2'(dec_pads[0]) - 2'(dec_pads[1]) : 2'd2;
				job.last      = in_last;
				job.err       = dec_bad;
			end else if (in_last) begin
				// truncated final group: one flagged zero item
				close         = 1'b1;
				job.final_idx = 2'd0;
				job.last      = 1'b1;
				job.err       = 1'b1;
			end else begin
				bits_d  = dec_bits;
				count_d = count_q + 2'd1;
				pads_d  = dec_pads;
				bad_d   = dec_bad;
			end
		end

		if (close) begin
			bits_d  = '0;
			count_d = '0;
			pads_d  = '0;
			bad_d   = 1'b0;
		end
	end

	assign job_push = accept && close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ENCODE;
			bits_q  <= '0;
			count_q <= '0;
			pads_q  <= '0;
			bad_q   <= 1'b0;
		end else if (mode_we) begin
			mode_q  <= mode_wdata;
			bits_q  <= '0;
			count_q <= '0;
			pads_q  <= '0;
			bad_q   <= 1'b0;
		end else if (accept) begin
			bits_q  <= bits_d;
			count_q <= count_d;
			pads_q  <= pads_d;
			bad_q   <= bad_d;
		end
	end

endmodule

// ----- sv/b64sc_queue.sv -----
// Short job queue between front and back of the Base64 codec.
// Depends on b64sc_pkg for the job type.
module b64sc_queue import b64sc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output job_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slots_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- sv/b64sc_back.sv -----
// Back end of the Base64 codec: walks the head job one item per cycle
// into the output register while it is empty or popped. Depends on b64sc_pkg.
module b64sc_back import b64sc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head,
	output logic       job_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_data,
	output logic       out_last,
	output logic       out_error
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       err_q;
	logic       load;
	logic       at_end;

	assign load    = head_valid && (!out_valid_q || pop);
	assign at_end  = (idx_q == head.final_idx);
	assign job_pop = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= head.data[idx_q];
			last_q <= head.last && at_end;
			err_q  <= head.err;
		end
	end

	assign empty     = !out_valid_q;
	assign out_data  = data_q;
	assign out_last  = last_q;
	assign out_error = err_q;

endmodule

// ----- sv/base64_stream_codec_unit.sv -----
// Top level of the streaming Base64 codec (standard alphabet, '=' padding).
// Depends on b64sc_pkg, b64sc_front, b64sc_queue and b64sc_back.
//
// The codec turns bytes into Base64 text (mode 0) or text back into bytes
// (mode 1). Both sides look like a queue: push an item while full is low,
// pop a result while empty is low. The front collects one item per cycle,
// while full is low, into a group and, when the group closes, hands a job
// of one to four results to a short queue; the back drains one result per
// cycle, while its output is empty or popped, into an output register, so
// input and output stall independently. In encode mode a group of three
// bytes yields four characters, so the input stalls on a full queue; in
// decode mode four characters yield at most three bytes, so one input item
// per cycle is sustained while results are popped. The first result of a
// group passes through the queue and then the output register before it
// is on the output ports and can be popped. in_last closes a partial
// group: encode pads it with '=', decode of a short final group gives one
// zero item flagged with out_error. Decoded bytes of a group holding a
// character outside the alphabet carry out_error. Write mode only while the
// codec is idle; the write also clears any partly collected group.
module base64_stream_codec_unit import b64sc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       mode_we,
	input  logic       mode_wdata,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_data,
	input  logic       in_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_data,
	output logic       out_last,
	output logic       out_error
);

	logic accept;
	logic job_push, job_pop, head_valid;
	job_t job, head;

	// take an item whenever the queue has room for the job it may close
	assign accept = push && !full;

	b64sc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_we    (mode_we),
		.mode_wdata (mode_wdata),
		.accept     (accept),
		.in_data    (in_data),
		.in_last    (in_last),
		.job_push   (job_push),
		.job        (job)
	);

	b64sc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (job),
		.pop        (job_pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	b64sc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.job_pop    (job_pop),
		.pop        (pop),
		.empty      (empty),
		.out_data   (out_data),
		.out_last   (out_last),
		.out_error  (out_error)
	);

endmodule
